/* design/arls_pkg.sv */
`timescale 1ns / 1ps

package arls_pkg;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int HALF_W   = 15;
  localparam int LEVEL_W  = 15;
  localparam int SCALED_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int SENS_W   = 15;
  localparam int SUM_W    = 38;

  // shared multiplier operands and product
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  // square root datapath
  localparam int ROOT_W  = SUM_W / 2;
  localparam int SQREM_W = ROOT_W + 2;

  // iteration counter
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W - 1);

  // constants of the level arithmetic
  localparam logic [LEVEL_W-1:0]  FULL_SCALE     = 15'd16384;
  localparam logic [SCALED_W-1:0] SCALED_MAX     = 16'hFFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 16'd4588;
  localparam logic [SENS_W-1:0]   SENS_RESET     = 15'd3277;
  localparam logic [SUM_W-1:0]    SUM_MAX        = {SUM_W{1'b1}};
  localparam int                  ROUND_HALF     = 32768;

  // configuration register indexes
  localparam logic CFG_IDX_WEIGHT = 1'b0;
  localparam logic CFG_IDX_SENS   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_LEFT,
    S_SQ_RIGHT,
    S_ACC,
    S_DIV_MEAN,
    S_SQRT,
    S_SMOOTH_MUL,
    S_SMOOTH_UPD,
    S_DIV_SCALE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_LEFT,
    MUL_RIGHT,
    MUL_SMOOTH
  } mul_sel_t;

endpackage

/* design/audio_rms_level_smoother_unit.sv */
`timescale 1ns / 1ps

// stereo rms level meter with exponential smoothing
//
// input channel: in_valid/in_ready moves one stereo frame per transaction
// (left_sample, right_sample, last_frame). after the transaction cycle, one
// shared 17x17 multiplier squares the left and right halved samples on
// successive cycles and the sum is updated
// a buffer ends at a frame marked last_frame or at MAX_FRAMES frames; the
// closing frame then runs the end-of-buffer sequence on the same shared
// units: a 38-step restoring divide for the mean, a 19-step digit-by-digit
// square root, one multiply for the smoothing step and a second 38-step
// divide for the scaled level
// output channel: out_valid/out_ready carries rms_level, smoothed_level
// and scaled_level from an output register. a new frame is taken while a
// result waits; if another buffer finishes before the receiver takes the
// waiting result, the block holds in its done state with in_ready low
// configuration: cfg_write writes cfg_data into register cfg_index
// (0 smoothing_weight, 1 sensitivity) on the same edge
// reset: sum, count and smoothed level clear, registers take 4588 and 3277
module audio_rms_level_smoother_unit #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [arls_pkg::WEIGHT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [arls_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [arls_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                              last_frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [arls_pkg::LEVEL_W-1:0]      rms_level,
  output logic [arls_pkg::LEVEL_W-1:0]      smoothed_level,
  output logic [arls_pkg::SCALED_W-1:0]     scaled_level
);

  import arls_pkg::*;

  // sample count holds up to two samples per frame of a full buffer
  localparam int CNT_W = $clog2(2 * MAX_FRAMES + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(2 * MAX_FRAMES);
  // divider serves both the mean (by count) and the scaling (by sensitivity)
  localparam int DIV_W = (CNT_W > SENS_W) ? CNT_W : SENS_W;

  state_t state, state_next;

  // configuration registers
  logic [WEIGHT_W-1:0] smoothing_weight;
  logic [SENS_W-1:0]   sensitivity;

  // frame capture
  logic signed [HALF_W-1:0] left_half;
  logic signed [HALF_W-1:0] right_half;
  logic                     last_reg;

  // accumulation state
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] sample_count;

  // shared multiplier
  mul_sel_t                  mul_sel;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  // shared divide / root datapath
  logic [SUM_W-1:0]   dvd;
  logic [DIV_W-1:0]   div_rem;
  logic [DIV_W-1:0]   divisor;
  logic [STEP_W-1:0]  step;
  logic [SQREM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]  sq_root;

  logic [LEVEL_W-1:0] rms_reg;
  logic [LEVEL_W-1:0] smoothed_store;

  logic load_out;

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic             buffer_end;
  logic             out_free;

  always_comb begin
    sum_add    = {1'b0, square_sum} + (SUM_W + 1)'($unsigned(prod));
    sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    count_next = sample_count + CNT_W'(2);
    buffer_end = last_reg || (count_next >= CNT_LIMIT);
    out_free   = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_SQ_LEFT;
      S_SQ_LEFT:    state_next = S_SQ_RIGHT;
      S_SQ_RIGHT:   state_next = S_ACC;
      S_ACC:        state_next = buffer_end ? S_DIV_MEAN : S_IDLE;
      S_DIV_MEAN:   if (step == '0) state_next = S_SQRT;
      S_SQRT:       if (step == '0) state_next = S_SMOOTH_MUL;
      S_SMOOTH_MUL: state_next = S_SMOOTH_UPD;
      S_SMOOTH_UPD: state_next = S_DIV_SCALE;
      S_DIV_SCALE:  if (step == '0) state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------------
  // control outputs
  // ------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mul_sel  = MUL_LEFT;
    case (state)
      S_IDLE:       in_ready = 1'b1;
      S_SQ_LEFT:    mul_sel  = MUL_LEFT;
      S_SQ_RIGHT:   mul_sel  = MUL_RIGHT;
      S_SMOOTH_MUL: mul_sel  = MUL_SMOOTH;
      S_DONE:       load_out = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= WEIGHT_RESET;
      sensitivity      <= SENS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_WEIGHT: smoothing_weight <= cfg_data;
        CFG_IDX_SENS:   sensitivity      <= cfg_data[SENS_W-1:0];
        default:        smoothing_weight <= smoothing_weight;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // shared multiplier: squares of halved samples, then the smoothing product
  // ------------------------------------------------------------------
  logic [LEVEL_W-1:0]      rms_clamp;
  logic signed [MUL_W-1:0] level_diff;

  always_comb begin
    rms_clamp  = (sq_root > ROOT_W'(FULL_SCALE)) ? FULL_SCALE : sq_root[LEVEL_W-1:0];
    // the root is final once the square root steps end
    level_diff = $signed({2'b00, rms_clamp}) - $signed({2'b00, smoothed_store});
    case (mul_sel)
      MUL_LEFT: begin
        mul_a = MUL_W'(left_half);
        mul_b = MUL_W'(left_half);
      end
      MUL_RIGHT: begin
        mul_a = MUL_W'(right_half);
        mul_b = MUL_W'(right_half);
      end
      MUL_SMOOTH: begin
        mul_a = level_diff;
        mul_b = $signed({1'b0, smoothing_weight});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ------------------------------------------------------------------
  // divide step (restoring, one quotient bit a cycle)
  // ------------------------------------------------------------------
  logic [DIV_W:0]   div_trial;
  logic             div_ge;
  logic [DIV_W:0]   div_diff;
  logic [DIV_W-1:0] div_rem_next;

  always_comb begin
    div_trial    = {div_rem, dvd[SUM_W-1]};
    div_ge       = div_trial >= {1'b0, divisor};
    div_diff     = div_trial - {1'b0, divisor};
    div_rem_next = div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
  end

  // ------------------------------------------------------------------
  // square root step (two radicand bits a cycle)
  // ------------------------------------------------------------------
  logic [SQREM_W+1:0] sq_shift;
  logic [SQREM_W+1:0] sq_trial;
  logic               sq_ge;
  logic [SQREM_W+1:0] sq_diff;

  always_comb begin
    sq_shift = {sq_rem, dvd[SUM_W-1:SUM_W-2]};
    sq_trial = (SQREM_W + 2)'({sq_root, 2'b01});
    sq_ge    = sq_shift >= sq_trial;
    sq_diff  = sq_shift - sq_trial;
  end

  // ------------------------------------------------------------------
  // smoothing update and scaling dividend
  // ------------------------------------------------------------------
  localparam int T_W     = PROD_W + 1;
  localparam int DELTA_W = T_W - 16;
  localparam int NS_W    = DELTA_W + 1;

  logic signed [T_W-1:0]     round_t;
  logic signed [DELTA_W-1:0] delta;
  logic signed [NS_W-1:0]    ns_wide;
  logic [LEVEL_W-1:0]        ns;
  logic [SUM_W-1:0]          scale_dvd;
  logic [SENS_W-1:0]         sens_eff;
  logic [SCALED_W-1:0]       scaled_clamp;

  always_comb begin
    round_t = T_W'(prod) + T_W'(ROUND_HALF);
    // arithmetic shift gives the floor for negative values too
    delta   = DELTA_W'(round_t >>> 16);
    ns_wide = $signed({{(NS_W - LEVEL_W){1'b0}}, smoothed_store}) + NS_W'(delta);
    if (ns_wide < 0) begin
      ns = '0;
    end else if (ns_wide > $signed(NS_W'(FULL_SCALE))) begin
      ns = FULL_SCALE;
    end else begin
      ns = ns_wide[LEVEL_W-1:0];
    end
    // ns * 65535 as shift and subtract
    scale_dvd = {ns, 16'd0} - SUM_W'(ns);
    sens_eff  = (sensitivity == '0) ? SENS_W'(1) : sensitivity;
    scaled_clamp = (dvd > SUM_W'(SCALED_MAX)) ? SCALED_MAX : dvd[SCALED_W-1:0];
  end

  // ------------------------------------------------------------------
  // datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      sample_count   <= '0;
      smoothed_store <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (buffer_end) begin
            square_sum   <= '0;
            sample_count <= '0;
          end else begin
            square_sum   <= sum_next;
            sample_count <= count_next;
          end
        end
        S_SQ_RIGHT: square_sum <= sum_next;
        S_SMOOTH_UPD: smoothed_store <= ns;
        default: begin
          square_sum <= square_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        left_half  <= HALF_W'(left_sample >>> 1);
        right_half <= HALF_W'(right_sample >>> 1);
        last_reg   <= last_frame;
      end
      S_ACC: begin
        dvd     <= sum_next;
        div_rem <= '0;
        divisor <= DIV_W'(count_next);
        step    <= DIV_STEPS;
      end
      S_DIV_MEAN: begin
        dvd     <= {dvd[SUM_W-2:0], div_ge};
        div_rem <= div_rem_next;
        step    <= (step == '0) ? SQRT_STEPS : step - STEP_W'(1);
        sq_rem  <= '0;
        sq_root <= '0;
      end
      S_SQRT: begin
        dvd     <= {dvd[SUM_W-3:0], 2'b00};
        sq_rem  <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_shift[SQREM_W-1:0];
        sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
        step    <= step - STEP_W'(1);
      end
      S_SMOOTH_MUL: rms_reg <= rms_clamp;
      S_SMOOTH_UPD: begin
        dvd     <= scale_dvd;
        div_rem <= '0;
        divisor <= DIV_W'(sens_eff);
        step    <= DIV_STEPS;
      end
      S_DIV_SCALE: begin
        dvd     <= {dvd[SUM_W-2:0], div_ge};
        div_rem <= div_rem_next;
        step    <= step - STEP_W'(1);
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rms_level      <= rms_reg;
      smoothed_level <= smoothed_store;
      scaled_level   <= scaled_clamp;
    end
  end

endmodule
